[rtl/core/kat_pkg.sv]
// Shared types and constants for the keyed accumulate table.
// Used by kat_ctrl, kat_datapath and keyed_accumulate_table; no dependencies.
package kat_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 2;
  localparam int ID_W      = 32;
  localparam int Q_W       = 32;
  localparam int CNT_W     = 5;
  localparam int STAT_W    = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_FIND = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_MERGED   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_DELETED  = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_FOUND    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input item
    logic lookup;   // compare keys, read the slot store
    logic commit;   // update the table and load the result register
  } cmd_t;

endpackage

[rtl/core/keyed_accumulate_table.sv]
// Top level of the keyed accumulate table: controller, datapath and ports.
// Depends on kat_pkg, kat_ctrl and kat_datapath.
//
// A table of DEPTH slots keyed by a 32-bit id, each holding a saturating
// Q16.16 weight and a Q16.16 price. Each operation (add or merge, delete,
// lookup, no-op) gives one result with status, weight, price and the entry
// count after the operation. An item passes through a lookup state, which
// compares the id against every key register in parallel and reads the
// matching slot from the weight/price store, and then an update state, which
// updates the table and loads the result register. While busy, a new item is
// accepted only in the cycle the current result is loaded; a result still
// waiting in the output register does not block the next item's compare.
// Valid bits are flip-flops cleared by reset, so the table is usable the cycle
// after reset. The capacity register takes a write on every transfer on the
// configuration port and should be written only while the block is idle.
module keyed_accumulate_table #(
  parameter int DEPTH = kat_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kat_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kat_pkg::OP_W-1:0]   in_opcode,
  input  logic signed [kat_pkg::ID_W-1:0] in_item_id,
  input  logic [kat_pkg::Q_W-1:0]    in_add_weight,
  input  logic [kat_pkg::Q_W-1:0]    in_add_price,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kat_pkg::STAT_W-1:0] out_status,
  output logic [kat_pkg::Q_W-1:0]    out_entry_weight,
  output logic [kat_pkg::Q_W-1:0]    out_entry_price,
  output logic [kat_pkg::CNT_W-1:0]  out_entry_count
);
  import kat_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  kat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  kat_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .in_opcode  (in_opcode),
    .in_key     ($unsigned(in_item_id)),
    .in_weight  (in_add_weight),
    .in_price   (in_add_price),
    .res_status (out_status),
    .res_weight (out_entry_weight),
    .res_price  (out_entry_price),
    .res_count  (out_entry_count)
  );

endmodule

[rtl/core/kat_ctrl.sv]
// Controller state machine for the keyed accumulate table.
// Depends on kat_pkg; drives kat_datapath through a cmd_t bundle.
module kat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output kat_pkg::cmd_t cmd
);
  import kat_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_r_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_UPD;
      S_UPD: begin
        if (out_free) state_nxt = in_valid ? S_LOOK : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_LOOK: cmd.lookup = 1'b1;
      S_UPD: begin
        // The next item may enter in the cycle the current result is loaded.
        in_ready   = out_free;
        cmd.commit = out_free;
      end
      default: ;
    endcase
    cmd.capture = in_valid && in_ready;
  end

  always_comb begin
    out_valid_r_nxt = out_valid_r;
    if (cmd.commit) out_valid_r_nxt = 1'b1;
    else if (out_ready) out_valid_r_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_r_nxt;
    end
  end

endmodule

[rtl/core/kat_datapath.sv]
// Datapath of the keyed accumulate table: key registers, valid bits, slot store,
// parallel key compare, saturating merge and the result register. Depends on kat_pkg.
module kat_datapath #(
  parameter int DEPTH = kat_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kat_pkg::cmd_t              cmd,
  input  logic                       cfg_we,
  input  logic [kat_pkg::CNT_W-1:0]  cfg_data,
  input  logic [kat_pkg::OP_W-1:0]   in_opcode,
  input  logic [kat_pkg::ID_W-1:0]   in_key,
  input  logic [kat_pkg::Q_W-1:0]    in_weight,
  input  logic [kat_pkg::Q_W-1:0]    in_price,
  output logic [kat_pkg::STAT_W-1:0] res_status,
  output logic [kat_pkg::Q_W-1:0]    res_weight,
  output logic [kat_pkg::Q_W-1:0]    res_price,
  output logic [kat_pkg::CNT_W-1:0]  res_count
);
  import kat_pkg::*;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_MAX = (DEPTH < 32) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] LIM_MAX_C = CNT_W'(LIM_MAX);

  // Captured item.
  op_t              op_r;
  logic [ID_W-1:0]  key_r;
  logic [Q_W-1:0]   w_r;
  logic [Q_W-1:0]   p_r;

  // Table state.
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r, cnt_r_nxt;
  logic [DEPTH-1:0] valid_r;
  logic [ID_W-1:0]  key_mem [DEPTH];
  logic [2*Q_W-1:0] slot_mem [DEPTH];

  // Lookup stage results.
  logic [DEPTH-1:0] match;
  logic             hit_any, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic             hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic [2*Q_W-1:0] rd_r;

  // Update stage.
  logic [Q_W:0]     sum;
  logic [Q_W-1:0]   sat;
  logic [Q_W-1:0]   rd_w, rd_p;
  logic [CNT_W-1:0] limit;
  logic             full;
  logic             mem_we, key_we, valid_set, valid_clr;
  logic [IDX_W-1:0] waddr;
  logic [2*Q_W-1:0] wdata;
  status_t          stat_nxt;
  logic [Q_W-1:0]   ow_nxt, op_nxt;

  // Result register.
  status_t          stat_r;
  logic [Q_W-1:0]   ow_r, opr_r;
  logic [CNT_W-1:0] ocnt_r;

  // Keys are unique among valid slots, so at most one match bit is set and
  // the hit index is a plain OR of the matching indices.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = valid_r[i] && (key_mem[i] == key_r);
      if (match[i]) hit_idx = hit_idx | IDX_W'(i);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
    hit_any = |match;
  end

  assign rd_w  = rd_r[2*Q_W-1:Q_W];
  assign rd_p  = rd_r[Q_W-1:0];
  assign sum   = {1'b0, rd_w} + {1'b0, w_r};
  assign sat   = sum[Q_W] ? '1 : sum[Q_W-1:0];
  assign limit = (cap_r < LIM_MAX_C) ? cap_r : LIM_MAX_C;
  assign full  = (cnt_r >= limit) || !free_r;

  always_comb begin
    mem_we    = 1'b0;
    key_we    = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    waddr     = hit_idx_r;
    wdata     = {sat, rd_p};
    cnt_r_nxt = cnt_r;
    stat_nxt  = STAT_NOTFOUND;
    ow_nxt    = '0;
    op_nxt    = '0;
    unique case (op_r)
      OP_ADD: begin
        if (hit_r) begin
          mem_we   = 1'b1;
          stat_nxt = STAT_MERGED;
          ow_nxt   = sat;
          op_nxt   = rd_p;
        end else if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          mem_we    = 1'b1;
          key_we    = 1'b1;
          valid_set = 1'b1;
          waddr     = free_idx_r;
          wdata     = {w_r, p_r};
          cnt_r_nxt = cnt_r + 1'b1;
          stat_nxt  = STAT_INSERTED;
          ow_nxt    = w_r;
          op_nxt    = p_r;
        end
      end
      OP_DEL: begin
        if (hit_r) begin
          valid_clr = 1'b1;
          if (cnt_r != '0) cnt_r_nxt = cnt_r - 1'b1;
          stat_nxt  = STAT_DELETED;
          ow_nxt    = rd_w;
          op_nxt    = rd_p;
        end
      end
      OP_FIND: begin
        if (hit_r) begin
          stat_nxt = STAT_FOUND;
          ow_nxt   = rd_w;
          op_nxt   = rd_p;
        end
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      cnt_r   <= '0;
      valid_r <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.commit) begin
        cnt_r <= cnt_r_nxt;
        if (valid_set) valid_r[free_idx_r] <= 1'b1;
        if (valid_clr) valid_r[hit_idx_r]  <= 1'b0;
      end
    end
  end

  // Payload registers and the slot store.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_opcode);
      key_r <= in_key;
      w_r   <= in_weight;
      p_r   <= in_price;
    end
    if (cmd.lookup) begin
      hit_r      <= hit_any;
      hit_idx_r  <= hit_idx;
      free_r     <= free_any;
      free_idx_r <= free_idx;
      rd_r       <= slot_mem[hit_idx];
    end
    if (cmd.commit) begin
      if (mem_we) slot_mem[waddr] <= wdata;
      if (key_we) key_mem[free_idx_r] <= key_r;
      stat_r <= stat_nxt;
      ow_r   <= ow_nxt;
      opr_r  <= op_nxt;
      ocnt_r <= cnt_r_nxt;
    end
  end

  assign res_status = stat_r;
  assign res_weight = ow_r;
  assign res_price  = opr_r;
  assign res_count  = ocnt_r;

endmodule

[bench/tb_keyed_accumulate_table.sv]
`timescale 1ns / 1ps
// Self-checking bench for keyed_accumulate_table: directed table, then random phases.
// Depends on kat_pkg and the keyed_accumulate_table RTL.
module tb_keyed_accumulate_table;
  import kat_pkg::*;

  localparam int TBL_DEPTH     = DEPTH_DEF;
  localparam int POOL_KEYS     = 24;
  localparam int DIRECTED_ROWS = 28;
  localparam int PHASES        = 6;

  typedef struct {
    status_t     status;
    logic [31:0] weight;
    logic [31:0] price;
    logic [4:0]  count;
  } table_result_t;

  // One line of stimulus: a capacity write (value in id) or a table operation,
  // optionally with its result written out by hand.
  typedef struct {
    bit            is_cfg;
    op_t           op;
    logic [31:0]   id;
    logic [31:0]   weight;
    logic [31:0]   price;
    bit            fixed;
    table_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_item_id = '0;
  logic [31:0] in_add_weight = '0;
  logic [31:0] in_add_price = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_entry_weight;
  logic [31:0] out_entry_price;
  logic [4:0]  out_entry_count;

  // Predicted table contents.
  bit          slot_used[TBL_DEPTH];
  logic [31:0] slot_id[TBL_DEPTH];
  logic [31:0] slot_wt[TBL_DEPTH];
  logic [31:0] slot_pr[TBL_DEPTH];
  int          used_count = 0;
  logic [4:0]  capacity_setting = CAP_RESET;

  table_result_t expected_results[$];
  logic [31:0]   key_pool[POOL_KEYS];
  int            error_count = 0;
  int            in_idle_pct = 0;
  int            out_stall_pct = 0;

  int         phase_in_idle[PHASES]  = '{0, 87, 0, 29, 0, 29};
  int         phase_out_stall[PHASES] = '{0, 0, 87, 29, 0, 29};
  int         phase_items[PHASES]    = '{140, 110, 110, 110, 40, 90};
  logic [4:0] phase_capacity[PHASES] = '{5'd16, 5'd9, 5'd16, 5'd4, 5'd0, 5'd16};

  plan_row_t directed_rows[DIRECTED_ROWS] = '{
    '{1'b0, OP_FIND, 'h00000000, 'h0, 'h0, 1'b1,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_DEL,  'h7FFFFFFF, 'h0, 'h0, 1'b1,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_NOP,  'h00000005, 'hFFFFFFFF, 'hFFFFFFFF, 1'b1,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h80000000, 'hFFFFFFFF, 'hFFFFFFFF, 1'b1,
      '{STAT_INSERTED, 'hFFFFFFFF, 'hFFFFFFFF, 5'd1}},
    '{1'b0, OP_ADD,  'h80000000, 'h00000001, 'h00000000, 1'b1,
      '{STAT_MERGED, 'hFFFFFFFF, 'hFFFFFFFF, 5'd1}},
    '{1'b0, OP_ADD,  'h7FFFFFFF, 'h0, 'h0, 1'b1,
      '{STAT_INSERTED, 'h0, 'h0, 5'd2}},
    '{1'b0, OP_ADD,  'h7FFFFFFF, 'h00018000, 'h12345678, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'hFFFFFFFF, 'h80000000, 'h00000001, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'hFFFFFFFF, 'h80000000, 'h00000000, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h00000000, 'hAAAA5555, 'h5555AAAA, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_FIND, 'h00000000, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_NOP,  'h00000000, 'h00000001, 'h00000001, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_DEL,  'h7FFFFFFF, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h00000001, 'h00010000, 'h00028000, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_FIND, 'h7FFFFFFF, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_DEL,  'h80000000, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_FIND, 'h00000001, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    // Capacity zero: new ids are rejected, merges still go through.
    '{1'b1, OP_NOP,  'd0, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h0000002A, 'h00000005, 'h00000005, 1'b1,
      '{STAT_FULL, 'h0, 'h0, 5'd3}},
    '{1'b0, OP_ADD,  'h00000000, 'h00000001, 'h00000000, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b1, OP_NOP,  'd3, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h0000002B, 'h00000001, 'h00000002, 1'b1,
      '{STAT_FULL, 'h0, 'h0, 5'd3}},
    // Capacity lowered below the current entry count.
    '{1'b1, OP_NOP,  'd2, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h0000002B, 'h00000001, 'h00000002, 1'b1,
      '{STAT_FULL, 'h0, 'h0, 5'd3}},
    '{1'b0, OP_DEL,  'hFFFFFFFF, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h0000002B, 'h00000001, 'h00000002, 1'b1,
      '{STAT_FULL, 'h0, 'h0, 5'd2}},
    '{1'b1, OP_NOP,  'd16, 'h0, 'h0, 1'b0,
      '{STAT_NOTFOUND, 'h0, 'h0, 5'd0}},
    '{1'b0, OP_ADD,  'h0000002B, 'h00000001, 'h00000002, 1'b1,
      '{STAT_INSERTED, 'h00000001, 'h00000002, 5'd3}}
  };

  keyed_accumulate_table u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_item_id       (in_item_id),
    .in_add_weight    (in_add_weight),
    .in_add_price     (in_add_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_weight (out_entry_weight),
    .out_entry_price  (out_entry_price),
    .out_entry_count  (out_entry_count)
  );

  always #5 clk = ~clk;

  // Applies one operation to the predicted table and returns its result.
  function automatic table_result_t apply_table_op(op_t op, logic [31:0] id,
                                                   logic [31:0] w, logic [31:0] p);
    table_result_t r;
    int hit;
    int free_idx;
    int i;
    int limit;
    logic [32:0] sum;
    r.status = STAT_NOTFOUND;
    r.weight = '0;
    r.price  = '0;
    hit      = -1;
    free_idx = -1;
    // Scanning downward leaves the lowest free slot in free_idx.
    for (i = TBL_DEPTH - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_id[i] == id) hit = i;
      if (!slot_used[i]) free_idx = i;
    end
    limit = (capacity_setting < TBL_DEPTH) ? int'(capacity_setting) : TBL_DEPTH;
    case (op)
      OP_ADD: begin
        if (hit >= 0) begin
          sum = {1'b0, slot_wt[hit]} + {1'b0, w};
          slot_wt[hit] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
          r.status = STAT_MERGED;
          r.weight = slot_wt[hit];
          r.price  = slot_pr[hit];
        end else if (used_count >= limit || free_idx < 0) begin
          r.status = STAT_FULL;
        end else begin
          slot_used[free_idx] = 1'b1;
          slot_id[free_idx]   = id;
          slot_wt[free_idx]   = w;
          slot_pr[free_idx]   = p;
          used_count++;
          r.status = STAT_INSERTED;
          r.weight = w;
          r.price  = p;
        end
      end
      OP_DEL: begin
        if (hit >= 0) begin
          r.status = STAT_DELETED;
          r.weight = slot_wt[hit];
          r.price  = slot_pr[hit];
          slot_used[hit] = 1'b0;
          used_count--;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          r.status = STAT_FOUND;
          r.weight = slot_wt[hit];
          r.price  = slot_pr[hit];
        end
      end
      default: begin
      end
    endcase
    r.count = used_count[4:0];
    return r;
  endfunction

  // Random operation, biased toward ids that are present or drawn from a fixed key pool.
  function automatic plan_row_t random_row();
    plan_row_t row;
    int pick;
    int i;
    pick       = $urandom_range(99);
    row.is_cfg = 1'b0;
    row.fixed  = 1'b0;
    row.op     = (pick < 45) ? OP_ADD : (pick < 72) ? OP_DEL : (pick < 95) ? OP_FIND : OP_NOP;
    if (row.op != OP_ADD && used_count > 0 && $urandom_range(1) == 1) begin
      i = $urandom_range(TBL_DEPTH - 1);
      while (!slot_used[i]) i = (i + 1) % TBL_DEPTH;
      row.id = slot_id[i];
    end else if ($urandom_range(9) == 0) begin
      row.id = $urandom;
    end else begin
      row.id = key_pool[$urandom_range(POOL_KEYS - 1)];
    end
    case ($urandom_range(2))
      0:       row.weight = $urandom_range('h3FFFF);
      1:       row.weight = $urandom;
      default: row.weight = {16'hFFFF, 16'($urandom)};
    endcase
    row.price = $urandom;
    return row;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  // Starts right after the previous transfer, so a gap drops valid in that same step.
  task automatic send_item(plan_row_t row);
    table_result_t predicted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= row.op;
    in_item_id    <= row.id;
    in_add_weight <= row.weight;
    in_add_price  <= row.price;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_table_op(row.op, row.id, row.weight, row.price);
    if (row.fixed) predicted = row.want;
    expected_results.insert(expected_results.size(), predicted);
  endtask

  // Stops input and waits for every outstanding result plus the pipeline depth.
  task automatic settle_table();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_setting = value;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", out_status));
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("entry_weight", out_entry_weight, want.weight);
        check_field("entry_price", out_entry_price, want.price);
        check_field("entry_count", 32'(out_entry_count), 32'(want.count));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_keyed_accumulate_table: done, errors");
    $finish;
  end

  initial begin
    int r;
    int ph;
    int n;
    key_pool[0] = 32'h80000000;
    key_pool[1] = 32'h7FFFFFFF;
    key_pool[2] = 32'h00000000;
    key_pool[3] = 32'hFFFFFFFF;
    key_pool[4] = 32'h00000001;
    for (r = 5; r < POOL_KEYS; r++) key_pool[r] = $urandom;
    for (r = 0; r < TBL_DEPTH; r++) slot_used[r] = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].is_cfg) begin
        settle_table();
        write_capacity(directed_rows[r].id[4:0]);
      end else begin
        send_item(directed_rows[r]);
      end
    end

    // Each phase starts from an idle block, which also makes the sender wait
    // for every outstanding result at least once.
    for (ph = 0; ph < PHASES; ph++) begin
      settle_table();
      in_idle_pct   = phase_in_idle[ph];
      out_stall_pct = phase_out_stall[ph];
      write_capacity(phase_capacity[ph]);
      for (n = 0; n < phase_items[ph]; n++) send_item(random_row());
    end

    settle_table();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_keyed_accumulate_table: done, clean");
    end else begin
      $display("tb_keyed_accumulate_table: done, errors");
    end
    $finish;
  end

endmodule
